// ===== hw/rtl/mmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Multiset maximum tracker package
// Shared types, codes and default sizes for the tracker and its count store.
// ----------------------------------------------------------------------------
package mmt_pkg;

  // Default sizes of the count store
  localparam int unsigned NumValuesDef  = 256;
  localparam int unsigned CountWidthDef = 16;

  // Field widths fixed by the interface
  localparam int unsigned ValW  = 8;
  localparam int unsigned CfgW  = 9;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Largest value after reset, before anything has been added
  localparam logic [ValW-1:0] LargestReset = ValW'(2);

  // Override register after reset: negative, so the override is off
  localparam logic [CfgW-1:0] CustomTolReset = '1;

  // Register index of the override, taken from paddr[2]
  localparam logic RegCustomTol = 1'b0;

  // Item kinds
  typedef enum logic {
    KIND_ADD    = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN
  } state_e;

  // Input word
  typedef struct packed {
    logic            kind;
    logic [ValW-1:0] tolerance_value;
  } in_t;

  // Result word
  typedef struct packed {
    logic [ValW-1:0] current_tolerance;
    logic            underflow;
  } out_t;

endpackage

// ===== hw/rtl/mmt_store.sv =====
// ----------------------------------------------------------------------------
// Count store
// Single-port-write, single-port-read memory with a registered read word.
// ----------------------------------------------------------------------------
module mmt_store #(
  parameter int unsigned Depth = mmt_pkg::NumValuesDef,
  parameter int unsigned Width = mmt_pkg::CountWidthDef + 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/multiset_max_tracker.sv =====
// ----------------------------------------------------------------------------
// Multiset maximum tracker
// Keeps a use count and a seen flag per tolerance value and tracks the
// largest value in use; a result gives the override or the tracked largest.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-----------------------------
//  input    | start high while busy low       | item_i  (mmt_pkg::in_t)
//  result   | res_strobe_o, one cycle, no stall| res_o  (mmt_pkg::out_t)
//  config   | psel, penable, pwrite, pready   | paddr, pwdata / prdata
//
//  After reset a clearing pass writes every store entry, with busy high.
//  An item then goes through the store read, then the count update, which
//  registers the result word and strobe. A remove that empties the largest
//  value adds a top-down scan of the store, one entry a cycle through the
//  single read port. The result strobe shows in the cycle busy falls; the
//  receiver cannot stall it.
//
module multiset_max_tracker #(
  parameter int unsigned NUM_VALUES  = mmt_pkg::NumValuesDef,
  parameter int unsigned COUNT_WIDTH = mmt_pkg::CountWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mmt_pkg::in_t                item_i,
  output logic                        res_strobe_o,
  output mmt_pkg::out_t               res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mmt_pkg::PaddrW-1:0]  paddr,
  input  logic [mmt_pkg::PdataW-1:0]  pwdata,
  output logic [mmt_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned IdxW = $clog2(NUM_VALUES);
  localparam int unsigned EntW = COUNT_WIDTH + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_VALUES - 1);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  mmt_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] clr_addr_q, clr_addr_d;
  logic kind_q, kind_d;
  logic [mmt_pkg::ValW-1:0] val_q, val_d;
  logic [mmt_pkg::ValW-1:0] largest_q, largest_d;
  logic any_seen_q, any_seen_d;
  logic [IdxW-1:0] scan_addr_q, scan_addr_d;
  logic [IdxW-1:0] chk_addr_q, chk_addr_d;
  logic chk_vld_q, chk_vld_d;
  logic res_strobe_q, res_strobe_d;
  mmt_pkg::out_t res_q, res_d;
  logic [mmt_pkg::CfgW-1:0] cust_q;

  logic mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0] mem_wdata, mem_rdata;
  logic rd_seen;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic in_range;
  logic [IdxW-1:0] val_idx;
  logic emit, uf;

  mmt_store #(
    .Depth(NUM_VALUES),
    .Width(EntW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign rd_seen  = mem_rdata[EntW-1];
  assign rd_cnt   = mem_rdata[COUNT_WIDTH-1:0];
  assign in_range = 32'(val_q) < 32'(NUM_VALUES);
  assign val_idx  = IdxW'(val_q);

  // Sequencer: clear, read, update, optional scan
  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    kind_d       = kind_q;
    val_d        = val_q;
    largest_d    = largest_q;
    any_seen_d   = any_seen_q;
    scan_addr_d  = scan_addr_q;
    chk_addr_d   = chk_addr_q;
    chk_vld_d    = 1'b0;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    mem_we       = 1'b0;
    mem_waddr    = val_idx;
    mem_wdata    = '0;
    mem_raddr    = scan_addr_q;
    emit         = 1'b0;
    uf           = 1'b0;

    unique case (state_q)
      mmt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        if (clr_addr_q == LastIdx) begin
          state_d = mmt_pkg::ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end

      mmt_pkg::ST_IDLE: begin
        mem_raddr = IdxW'(item_i.tolerance_value);
        if (start) begin
          kind_d  = item_i.kind;
          val_d   = item_i.tolerance_value;
          state_d = mmt_pkg::ST_RMW;
        end
      end

      mmt_pkg::ST_RMW: begin
        emit    = 1'b1;
        state_d = mmt_pkg::ST_IDLE;
        if (in_range) begin
          if (kind_q == mmt_pkg::KIND_ADD) begin
            if (rd_seen) begin
              if (rd_cnt != CountMax) begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, rd_cnt + 1'b1};
                if (rd_cnt == '0 && val_q > largest_q) begin
                  largest_d = val_q;
                end
              end
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, COUNT_WIDTH'(1)};
              if (!any_seen_q) begin
                largest_d  = val_q;
                any_seen_d = 1'b1;
              end else if (val_q > largest_q) begin
                largest_d = val_q;
              end
            end
          end else if (rd_seen) begin
            if (rd_cnt == '0) begin
              uf = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, rd_cnt - 1'b1};
              // Largest value emptied: hunt for the next one
              if (val_q == largest_q && rd_cnt == COUNT_WIDTH'(1)) begin
                emit        = 1'b0;
                state_d     = mmt_pkg::ST_SCAN;
                scan_addr_d = LastIdx;
              end
            end
          end
        end
      end

      mmt_pkg::ST_SCAN: begin
        if (chk_vld_q && rd_cnt != '0) begin
          largest_d = mmt_pkg::ValW'(chk_addr_q);
          emit      = 1'b1;
          state_d   = mmt_pkg::ST_IDLE;
        end else if (chk_vld_q && chk_addr_q == '0) begin
          largest_d = '0;
          emit      = 1'b1;
          state_d   = mmt_pkg::ST_IDLE;
        end else begin
          chk_vld_d   = 1'b1;
          chk_addr_d  = scan_addr_q;
          scan_addr_d = scan_addr_q - 1'b1;
        end
      end

      default: begin
        state_d = mmt_pkg::ST_IDLE;
      end
    endcase

    // Form the result word
    if (emit) begin
      res_strobe_d            = 1'b1;
      res_d.current_tolerance = cust_q[mmt_pkg::CfgW-1] ? largest_d
                                                         : cust_q[mmt_pkg::ValW-1:0];
      res_d.underflow         = uf;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mmt_pkg::ST_CLEAR;
      clr_addr_q   <= '0;
      largest_q    <= mmt_pkg::LargestReset;
      any_seen_q   <= 1'b0;
      chk_vld_q    <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      largest_q    <= largest_d;
      any_seen_q   <= any_seen_d;
      chk_vld_q    <= chk_vld_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  // Item and scan payload
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    val_q       <= val_d;
    scan_addr_q <= scan_addr_d;
    chk_addr_q  <= chk_addr_d;
    res_q       <= res_d;
  end

  // Override register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cust_q <= mmt_pkg::CustomTolReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == mmt_pkg::RegCustomTol) begin
      cust_q <= pwdata[mmt_pkg::CfgW-1:0];
    end
  end

  // Read back, sign-extended
  always_comb begin
    prdata = '0;
    if (paddr[2] == mmt_pkg::RegCustomTol) begin
      prdata = {{(mmt_pkg::PdataW - mmt_pkg::CfgW){cust_q[mmt_pkg::CfgW-1]}}, cust_q};
    end
  end

  assign pready       = 1'b1;
  assign busy         = (state_q != mmt_pkg::ST_IDLE);
  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

// ===== bench/tb_multiset_max_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multiset maximum tracker testbench
// Drives add and remove words through the start/busy port and checks every
// result word against a behavioural scoreboard of the count and seen stores.
// The override register is set over APB between phases and read back.
// A directed run covers the corner cases, then random phases with a small
// value pool follow.
// ----------------------------------------------------------------------------
module tb_multiset_max_tracker;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 105;
  localparam logic [mmt_pkg::CfgW-1:0] OverrideOff = '1;

  // Behavioural scoreboard: shadow stores and queue of expected result words
  class tol_scoreboard;
    localparam int unsigned CountMax = (1 << mmt_pkg::CountWidthDef) - 1;

    int unsigned                  use_cnt [mmt_pkg::NumValuesDef];
    bit                           seen    [mmt_pkg::NumValuesDef];
    logic [mmt_pkg::ValW-1:0]     largest;
    bit                           any_added;
    logic [mmt_pkg::CfgW-1:0]     override_reg;
    mmt_pkg::out_t                expected_words [$];
    int unsigned                  mismatches;
    int unsigned                  items_seen;
    int unsigned                  results_seen;
    int unsigned                  underflows;

    function new();
      foreach (use_cnt[i]) begin
        use_cnt[i] = 0;
        seen[i]    = 1'b0;
      end
      largest        = mmt_pkg::LargestReset;
      any_added      = 1'b0;
      override_reg   = mmt_pkg::CustomTolReset;
      mismatches     = 0;
      items_seen     = 0;
      results_seen   = 0;
      underflows     = 0;
    endfunction

    // Print one line per mismatch and count it
    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    // Top-down search for the highest value still in use
    function logic [mmt_pkg::ValW-1:0] highest_in_use();
      for (int i = mmt_pkg::NumValuesDef - 1; i >= 0; i--) begin
        if (use_cnt[i] != 0) return mmt_pkg::ValW'(i);
      end
      return '0;
    endfunction

    // Update the shadow stores for an accepted word and queue its result
    function void note_item(mmt_pkg::in_t w);
      int unsigned   v;
      logic          uf;
      mmt_pkg::out_t want;
      v  = w.tolerance_value;
      uf = 1'b0;
      items_seen++;
      if (w.kind == mmt_pkg::KIND_ADD) begin
        if (!seen[v]) begin
          seen[v]    = 1'b1;
          use_cnt[v] = 1;
          // the very first add replaces the reset largest outright
          if (!any_added) begin
            largest   = w.tolerance_value;
            any_added = 1'b1;
          end else if (v > largest) begin
            largest = w.tolerance_value;
          end
        end else if (use_cnt[v] < CountMax) begin
          use_cnt[v]++;
          if (use_cnt[v] == 1 && v > largest) largest = w.tolerance_value;
        end
      end else if (seen[v]) begin
        if (use_cnt[v] == 0) begin
          uf = 1'b1;
          underflows++;
        end else begin
          use_cnt[v]--;
          if (v == largest && use_cnt[v] == 0) largest = highest_in_use();
        end
      end
      want.current_tolerance = override_reg[mmt_pkg::CfgW-1] ? largest
                                                             : override_reg[mmt_pkg::ValW-1:0];
      want.underflow = uf;
      expected_words.push_back(want);
    endfunction

    // Compare a result word with the oldest expectation
    task check_result(mmt_pkg::out_t got);
      mmt_pkg::out_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("result word tol=%0d uf=%0b with nothing expected",
                         got.current_tolerance, got.underflow));
        return;
      end
      want = expected_words.pop_front();
      results_seen++;
      if (got.current_tolerance !== want.current_tolerance)
        report($sformatf("result %0d: current_tolerance %0d, expected %0d",
                         results_seen, got.current_tolerance, want.current_tolerance));
      if (got.underflow !== want.underflow)
        report($sformatf("result %0d: underflow %0b, expected %0b",
                         results_seen, got.underflow, want.underflow));
    endtask
  endclass

  logic                       clk_i   = 1'b0;
  logic                       rst_ni  = 1'b0;
  logic                       start   = 1'b0;
  logic                       busy;
  mmt_pkg::in_t               item    = '0;
  logic                       res_strobe;
  mmt_pkg::out_t              res;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [mmt_pkg::PaddrW-1:0] paddr   = '0;
  logic [mmt_pkg::PdataW-1:0] pwdata  = '0;
  logic [mmt_pkg::PdataW-1:0] prdata;
  logic                       pready;

  tol_scoreboard sb;
  int unsigned   idle_cycles = 0;
  int unsigned   cfg_count   = 0;
  logic [mmt_pkg::ValW-1:0] pool [8];

  multiset_max_tracker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item),
    .res_strobe_o (res_strobe),
    .res_o        (res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock: 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Check result words and watch for a stalled run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_strobe) sb.check_result(res);
      if (res_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: no word moved for %0d cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic mmt_pkg::in_t mk(mmt_pkg::kind_e k, logic [mmt_pkg::ValW-1:0] v);
    mmt_pkg::in_t w;
    w.kind            = k;
    w.tolerance_value = v;
    return w;
  endfunction

  // Sender idles now and then, a few cycles at a time
  function automatic int unsigned pick_gap();
    return ($urandom_range(99) < 30) ? $urandom_range(4, 1) : 0;
  endfunction

  // Mostly pool values so counts rise and fall, plus extremes and noise
  function automatic mmt_pkg::in_t rand_item();
    int unsigned sel;
    logic [mmt_pkg::ValW-1:0] v;
    sel = $urandom_range(99);
    if (sel < 70) v = pool[$urandom_range(7)];
    else if (sel < 82) v = ($urandom_range(1) != 0) ? mmt_pkg::ValW'($urandom_range(1))
                                                     : mmt_pkg::ValW'(254 + $urandom_range(1));
    else v = mmt_pkg::ValW'($urandom_range(255));
    return mk(($urandom_range(99) < 45) ? mmt_pkg::KIND_ADD : mmt_pkg::KIND_REMOVE, v);
  endfunction

  // Present a word, hold it until accepted, leave start high on exit
  task automatic send_word(mmt_pkg::in_t w, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item  <= w;
    do begin
      @(posedge clk_i);
    end while (busy);
    sb.note_item(w);
  endtask

  // Drop start and wait until every expected word has come back
  task automatic drain();
    start <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (sb.expected_words.size() != 0 || busy);
  endtask

  // Write the override register, then read it back
  task automatic set_override(logic [mmt_pkg::CfgW-1:0] val);
    logic [mmt_pkg::PdataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {mmt_pkg::RegCustomTol, 2'b00};
    pwdata  <= {{(mmt_pkg::PdataW - mmt_pkg::CfgW){val[mmt_pkg::CfgW-1]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    sb.override_reg = val;
    cfg_count++;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[mmt_pkg::CfgW-1:0] !== val)
      sb.report($sformatf("override read back %0h, expected %0h",
                          rd[mmt_pkg::CfgW-1:0], val));
  endtask

  initial begin
    logic [mmt_pkg::CfgW-1:0] cfg;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_override(OverrideOff);

    // Directed: reset largest, first add, re-add, rescans, underflows
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd7), 0);
    send_word(mk(mmt_pkg::KIND_ADD, 8'd0), 0);
    send_word(mk(mmt_pkg::KIND_ADD, 8'd255), 1);
    send_word(mk(mmt_pkg::KIND_ADD, 8'd255), 0);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd255), 2);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd255), 0);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd255), 0);
    send_word(mk(mmt_pkg::KIND_ADD, 8'd255), 3);
    send_word(mk(mmt_pkg::KIND_ADD, 8'd128), 0);
    send_word(mk(mmt_pkg::KIND_ADD, 8'd1), 0);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd255), 1);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd0), 0);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd128), 0);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd1), 2);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd0), 0);
    send_word(mk(mmt_pkg::KIND_ADD, 8'd0), 0);
    send_word(mk(mmt_pkg::KIND_ADD, 8'd85), 1);
    send_word(mk(mmt_pkg::KIND_ADD, 8'd170), 0);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd170), 0);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd85), 0);
    send_word(mk(mmt_pkg::KIND_REMOVE, 8'd0), 4);
    drain();

    // Random phases, each with its override setting written first
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1:       cfg = 9'h0FF;
        3:       cfg = 9'h000;
        4:       cfg = {1'b0, mmt_pkg::ValW'($urandom_range(255))};
        default: cfg = OverrideOff;
      endcase
      set_override(cfg);
      foreach (pool[i]) pool[i] = mmt_pkg::ValW'($urandom_range(255));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // phase 2 runs back to back with no sender gaps
        send_word(rand_item(), (ph == 2) ? 0 : pick_gap());
      end
      drain();
    end

    // Let any stray strobe show up before closing
    repeat (mmt_pkg::NumValuesDef + 8) @(posedge clk_i);

    $display("Covered %0d input words, %0d result words checked, %0d override settings.",
             sb.items_seen, sb.results_seen, cfg_count);
    $display("Underflow removes seen: %0d.", sb.underflows);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
